FILE: hdl/reflow_profile_sequencer_defines.svh
// Assertion macros used by the reflow profile sequencer core.
`ifndef REFLOW_PROFILE_SEQUENCER_DEFINES_SVH
`define REFLOW_PROFILE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define RPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("reflow sequencer check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define RPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("reflow sequencer check failed");

`else

`define RPS_ASSERT_NOW(lbl, ante, cons)
`define RPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/rps_pkg.sv
// Types, constants and helper functions of the reflow profile sequencer.
package rps_pkg;

  localparam int TEMP_W    = 14;
  localparam int LAG_W     = 13;
  localparam int CFG_T_W   = 24;
  localparam int TIME_W    = 32;
  localparam int DUTY_W    = 11;
  localparam int SOAK_N_W  = 25;
  localparam int SOAK_Q_W  = 9;
  localparam int SOAK_P_W  = 56;
  localparam int SOAK_SHIFT = 47;

  localparam logic signed [TEMP_W-1:0] TRIP_TEMP      = 14'sd4000;
  localparam logic signed [TEMP_W-1:0] COOL_DONE_TEMP = 14'sd1600;

  localparam logic [DUTY_W-1:0] FULL_DUTY = 11'd1024;
  localparam logic [DUTY_W-1:0] DUTY_MIN  = 11'd51;
  localparam logic [DUTY_W-1:0] DUTY_MAX  = 11'd512;
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 11'd0;

  // Soak duty is floor(64*(6250*s - 5853368)/3297925). Below SOAK_S_LO it clamps
  // to the minimum, above SOAK_S_HI to the maximum; in between the division
  // is an exact multiply by ceil(2^53/3297925) followed by a shift.
  localparam logic signed [TEMP_W-1:0] SOAK_S_LO = 14'sd1358;
  localparam logic signed [TEMP_W-1:0] SOAK_S_HI = 14'sd5157;
  localparam logic signed [31:0] SOAK_SLOPE  = 32'sd6250;
  localparam logic signed [31:0] SOAK_OFFSET = 32'sd5853368;
  localparam logic [31:0] SOAK_RECIP = 32'd2731171648;

  localparam logic signed [TEMP_W-1:0] SOAK_TARGET_RST   = 14'sd2400;
  localparam logic signed [TEMP_W-1:0] REFLOW_TARGET_RST = 14'sd3680;
  localparam logic signed [LAG_W-1:0]  LAG_OFFSET_RST    = 13'sd1040;
  localparam logic [CFG_T_W-1:0] SOAK_TIME_RST   = 24'd90000;
  localparam logic [CFG_T_W-1:0] REFLOW_TIME_RST = 24'd60000;
  localparam logic [CFG_T_W-1:0] BOOST_TIME_RST  = 24'd30000;

  typedef enum logic [1:0] {
    MODE_UPDATE = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_PREHEAT = 3'd1,
    PH_SOAK    = 3'd2,
    PH_REFLOW  = 3'd3,
    PH_COOL    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    REG_SOAK_TARGET   = 3'd0,
    REG_REFLOW_TARGET = 3'd1,
    REG_LAG_OFFSET    = 3'd2,
    REG_SOAK_TIME     = 3'd3,
    REG_REFLOW_TIME   = 3'd4,
    REG_BOOST_TIME    = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [SOAK_N_W-1:0] n;
    logic                lo;
    logic                hi;
  } soak_prep_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] soak_target;
    logic signed [TEMP_W-1:0] reflow_target;
    logic signed [LAG_W-1:0]  lag_offset;
    logic [CFG_T_W-1:0]       soak_time_ms;
    logic [CFG_T_W-1:0]       reflow_time_ms;
    logic [CFG_T_W-1:0]       boost_time_ms;
    soak_prep_t               soak;
  } cfg_t;

  // Linear numerator and range flags of the soak duty, taken at reset and when the target is written.
  function automatic soak_prep_t soak_prep(input logic signed [TEMP_W-1:0] s);
    logic signed [31:0] lin;
    soak_prep_t r;
    lin  = $signed(32'(s)) * SOAK_SLOPE - SOAK_OFFSET;
    r.n  = lin[SOAK_N_W-1:0];
    r.lo = s < SOAK_S_LO;
    r.hi = s > SOAK_S_HI;
    return r;
  endfunction

endpackage

FILE: hdl/rps_cfg_regs.sv
// Configuration register bank with its APB-style access port.
module rps_cfg_regs
  import rps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic signed [TEMP_W-1:0] soak_target;
  logic signed [TEMP_W-1:0] reflow_target;
  logic signed [LAG_W-1:0]  lag_offset;
  logic [CFG_T_W-1:0]       soak_time_ms;
  logic [CFG_T_W-1:0]       reflow_time_ms;
  logic [CFG_T_W-1:0]       boost_time_ms;
  soak_prep_t               soak;
  logic                     wr_en;
  reg_idx_t                 idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      soak_target    <= SOAK_TARGET_RST;
      reflow_target  <= REFLOW_TARGET_RST;
      lag_offset     <= LAG_OFFSET_RST;
      soak_time_ms   <= SOAK_TIME_RST;
      reflow_time_ms <= REFLOW_TIME_RST;
      boost_time_ms  <= BOOST_TIME_RST;
      soak           <= soak_prep(SOAK_TARGET_RST);
    end else if (wr_en) begin
      unique case (idx)
        REG_SOAK_TARGET: begin
          soak_target <= pwdata[TEMP_W-1:0];
          soak        <= soak_prep(pwdata[TEMP_W-1:0]);
        end
        REG_REFLOW_TARGET: reflow_target  <= pwdata[TEMP_W-1:0];
        REG_LAG_OFFSET:    lag_offset     <= pwdata[LAG_W-1:0];
        REG_SOAK_TIME:     soak_time_ms   <= pwdata[CFG_T_W-1:0];
        REG_REFLOW_TIME:   reflow_time_ms <= pwdata[CFG_T_W-1:0];
        REG_BOOST_TIME:    boost_time_ms  <= pwdata[CFG_T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SOAK_TARGET:   prdata = {{(32-TEMP_W){soak_target[TEMP_W-1]}}, soak_target};
      REG_REFLOW_TARGET: prdata = {{(32-TEMP_W){reflow_target[TEMP_W-1]}}, reflow_target};
      REG_LAG_OFFSET:    prdata = {{(32-LAG_W){lag_offset[LAG_W-1]}}, lag_offset};
      REG_SOAK_TIME:     prdata = {{(32-CFG_T_W){1'b0}}, soak_time_ms};
      REG_REFLOW_TIME:   prdata = {{(32-CFG_T_W){1'b0}}, reflow_time_ms};
      REG_BOOST_TIME:    prdata = {{(32-CFG_T_W){1'b0}}, boost_time_ms};
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    cfg.soak_target    = soak_target;
    cfg.reflow_target  = reflow_target;
    cfg.lag_offset     = lag_offset;
    cfg.soak_time_ms   = soak_time_ms;
    cfg.reflow_time_ms = reflow_time_ms;
    cfg.boost_time_ms  = boost_time_ms;
    cfg.soak           = soak;
  end

endmodule

FILE: hdl/rps_soak_duty.sv
// Soak duty from the prepared soak target: reciprocal multiply and clamp.
module rps_soak_duty
  import rps_pkg::*;
(
  input  soak_prep_t        soak,
  output logic [DUTY_W-1:0] duty
);

  logic [SOAK_P_W-1:0] prod;
  logic [SOAK_Q_W-1:0] q;

  // Only meaningful inside the unclamped range; the flags override it elsewhere.
  assign prod = SOAK_P_W'(soak.n) * SOAK_P_W'(SOAK_RECIP);
  assign q    = prod[SOAK_SHIFT +: SOAK_Q_W];

  always_comb begin
    priority if (soak.lo) begin
      duty = DUTY_MIN;
    end else if (soak.hi) begin
      duty = DUTY_MAX;
    end else if (DUTY_W'(q) < DUTY_MIN) begin
      duty = DUTY_MIN;
    end else begin
      duty = DUTY_W'(q);
    end
  end

endmodule

FILE: hdl/rps_core.sv
// Event register, phase sequencer state and result register.
`include "reflow_profile_sequencer_defines.svh"

module rps_core
  import rps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic [DUTY_W-1:0] soak_duty,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [47:0]       s_tdata,
  input  logic [1:0]        s_tuser,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata
);

  // Event register
  logic                     in_valid;
  mode_t                    in_mode;
  logic signed [TEMP_W-1:0] in_temp;
  logic [TIME_W-1:0]        in_now;

  // Sequencer state
  logic              active;
  phase_t            phase;
  logic [TIME_W-1:0] phase_start;
  logic [DUTY_W-1:0] duty;
  logic              heater_on;

  logic              active_next;
  phase_t            phase_next;
  logic [TIME_W-1:0] phase_start_next;
  logic [DUTY_W-1:0] duty_next;
  logic              heater_next;
  logic              trip_c;
  logic              rej_c;
  logic              done_c;

  // Result register
  logic              out_valid;
  phase_t            out_phase;
  logic              out_running;
  logic              out_heater;
  logic [DUTY_W-1:0] out_duty;
  logic              out_trip;
  logic              out_rej;
  logic              out_done;

  logic                     adv;
  logic [TIME_W-1:0]        dur;
  logic signed [TEMP_W:0]   soak_thr;
  logic signed [TEMP_W:0]   reflow_thr;
  logic                     start_ok;
  logic                     trip_hit;
  logic                     to_soak;
  logic                     soak_over;
  logic                     reflow_over;
  logic                     boost;
  logic                     cool_done;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= mode_t'(s_tuser);
      in_temp <= s_tdata[TEMP_W-1:0];
      in_now  <= s_tdata[TEMP_W +: TIME_W];
    end
  end

  assign dur        = in_now - phase_start;
  assign soak_thr   = (TEMP_W+1)'(cfg.soak_target) - (TEMP_W+1)'(cfg.lag_offset);
  assign reflow_thr = (TEMP_W+1)'(cfg.reflow_target) - (TEMP_W+1)'(cfg.lag_offset);
  assign start_ok   = (cfg.soak_target > 0) && (cfg.reflow_target > 0);
  assign trip_hit   = in_temp > TRIP_TEMP;
  assign to_soak    = (TEMP_W+1)'(in_temp) >= soak_thr;
  assign soak_over  = dur >= TIME_W'(cfg.soak_time_ms);
  assign reflow_over = dur >= TIME_W'(cfg.reflow_time_ms);
  assign boost      = ((TEMP_W+1)'(in_temp) < reflow_thr) && (dur < TIME_W'(cfg.boost_time_ms));
  assign cool_done  = in_temp < COOL_DONE_TEMP;

  // Next phase and run flag
  always_comb begin
    phase_next  = phase;
    active_next = active;
    unique case (in_mode)
      MODE_START: begin
        if (start_ok) begin
          active_next = 1'b1;
          phase_next  = PH_PREHEAT;
        end
      end
      MODE_STOP: begin
        active_next = 1'b0;
        phase_next  = PH_IDLE;
      end
      MODE_UPDATE: begin
        if (active) begin
          if (trip_hit) begin
            active_next = 1'b0;
            phase_next  = PH_IDLE;
          end else begin
            unique case (phase)
              PH_PREHEAT: if (to_soak) phase_next = PH_SOAK;
              PH_SOAK:    if (soak_over) phase_next = PH_REFLOW;
              PH_REFLOW:  if (reflow_over) phase_next = PH_COOL;
              PH_COOL: begin
                if (cool_done) begin
                  active_next = 1'b0;
                  phase_next  = PH_IDLE;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  // Heater, duty, phase timestamp and event flags
  always_comb begin
    duty_next        = duty;
    heater_next      = heater_on;
    phase_start_next = phase_start;
    trip_c           = 1'b0;
    rej_c            = 1'b0;
    done_c           = 1'b0;
    unique case (in_mode)
      MODE_START: begin
        if (start_ok) begin
          heater_next      = 1'b1;
          duty_next        = FULL_DUTY;
          phase_start_next = in_now;
        end else begin
          rej_c = 1'b1;
        end
      end
      MODE_STOP: begin
        heater_next = 1'b0;
        duty_next   = DUTY_OFF;
      end
      MODE_UPDATE: begin
        if (active) begin
          if (trip_hit) begin
            heater_next = 1'b0;
            duty_next   = DUTY_OFF;
            trip_c      = 1'b1;
          end else begin
            unique case (phase)
              PH_PREHEAT: begin
                if (to_soak) begin
                  phase_start_next = in_now;
                end else begin
                  duty_next = FULL_DUTY;
                end
              end
              PH_SOAK: begin
                if (soak_over) begin
                  phase_start_next = in_now;
                  duty_next        = FULL_DUTY;
                end else begin
                  duty_next = soak_duty;
                end
              end
              PH_REFLOW: begin
                if (reflow_over) begin
                  phase_start_next = in_now;
                  heater_next      = 1'b0;
                  duty_next        = DUTY_OFF;
                end else begin
                  duty_next = boost ? FULL_DUTY : DUTY_OFF;
                end
              end
              PH_COOL: begin
                if (cool_done) begin
                  heater_next = 1'b0;
                  duty_next   = DUTY_OFF;
                  done_c      = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      phase       <= PH_IDLE;
      phase_start <= '0;
      duty        <= DUTY_OFF;
      heater_on   <= 1'b0;
    end else if (adv) begin
      active      <= active_next;
      phase       <= phase_next;
      phase_start <= phase_start_next;
      duty        <= duty_next;
      heater_on   <= heater_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_phase   <= phase_next;
      out_running <= active_next;
      out_heater  <= heater_next;
      out_duty    <= duty_next;
      out_trip    <= trip_c;
      out_rej     <= rej_c;
      out_done    <= done_c;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'b0, out_done, out_rej, out_trip, out_duty, out_heater,
                     out_running, out_phase};

  `RPS_ASSERT_NOW(a_active_matches_phase, 1'b1, active == (phase != PH_IDLE))
  `RPS_ASSERT_NOW(a_heater_off_no_duty, !heater_on, duty == DUTY_OFF)
  `RPS_ASSERT_NOW(a_duty_in_range, 1'b1, duty <= FULL_DUTY)
  `RPS_ASSERT_NOW(a_trip_ends_run, out_valid && out_trip,
                  !out_running && (out_phase == PH_IDLE) && !out_heater)
  `RPS_ASSERT_NEXT(a_reject_keeps_state, adv && rej_c,
                   $stable(phase) && $stable(active) && $stable(duty))

endmodule

FILE: hdl/reflow_profile_sequencer.sv
// Reflow oven profile sequencer: event stream in, heater command stream out.
//
// Each request on the s_ side is one event: tuser carries the kind (update,
// start or stop), tdata the temperature sample and the millisecond time.
// Each event yields exactly one result on the m_ side: the phase, run flag,
// heater enable and duty after the event, plus trip, reject and run-complete
// flags. Thresholds and phase lengths sit in the APB register bank and are to be
// written between runs of traffic by the user; the block does not enforce it.
//
// An event is registered on acceptance, and its result is registered in the
// result register as the event advances, unless the receiver stalls. One
// event per cycle is sustained while the receiver is ready; the rate is set
// by the single compare-and-update pass over the sequencer state between the
// two registers. When the receiver stalls, the held result waits in the
// output register and one more event is taken into the event register
// before s_tready drops. Synchronous reset restores the register defaults,
// clears both stages and puts the sequencer idle with the heater off.
module reflow_profile_sequencer
  import rps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // temperature[13:0], now_ms[45:14], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // phase[2:0], running[3], heater_enable[4],
                                 // duty[15:5], emergency_trip[16],
                                 // start_rejected[17], run_complete[18], zero pad
);

  cfg_t              cfg;
  logic [DUTY_W-1:0] soak_duty;

  rps_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rps_soak_duty u_soak (
    .soak (cfg.soak),
    .duty (soak_duty)
  );

  rps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .soak_duty (soak_duty),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

FILE: tb/rps_checker.sv
// Checker for the reflow profile sequencer: mirrors its state and compares every command.
module rps_checker
  import rps_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [47:0] s_tdata,   // temperature[13:0], now_ms[45:14], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // phase[2:0], running[3], heater_enable[4], duty[15:5],
                                 // emergency_trip[16], start_rejected[17],
                                 // run_complete[18], zero pad
  output int          errors,
  output int          pending,
  output int          checked,
  output int          trips,
  output int          finishes,
  output int          refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  // Field order matches the low 19 bits of m_tdata.
  typedef struct packed {
    logic              run_complete;
    logic              start_rejected;
    logic              emergency_trip;
    logic [DUTY_W-1:0] duty;
    logic              heater_enable;
    logic              running;
    phase_t            phase;
  } heater_cmd_t;

  localparam longint SOAK_SCALE  = 100000;
  localparam longint SOAK_BIAS   = 93653888;
  localparam longint SOAK_GAIN   = 64;
  localparam longint SOAK_DIVIDE = 52766800;

  logic signed [TEMP_W-1:0] soak_tgt, reflow_tgt;
  logic signed [LAG_W-1:0]  lag;
  logic [CFG_T_W-1:0]       soak_len, reflow_len, boost_len;

  logic              in_run;
  phase_t            cur_phase;
  logic [TIME_W-1:0] phase_t0;
  logic [DUTY_W-1:0] duty_q;
  logic              heat;

  heater_cmd_t pending_cmds[$];

  function automatic logic [DUTY_W-1:0] soak_level(input logic signed [TEMP_W-1:0] tgt);
    longint num, q;
    num = (longint'(tgt) * SOAK_SCALE - SOAK_BIAS) * SOAK_GAIN;
    if (num < 0) return DUTY_MIN;
    q = num / SOAK_DIVIDE;
    if (q < longint'(DUTY_MIN)) q = longint'(DUTY_MIN);
    if (q > longint'(DUTY_MAX)) q = longint'(DUTY_MAX);
    return q[DUTY_W-1:0];
  endfunction

  function automatic void halt_run();
    in_run = 1'b0;
    cur_phase = PH_IDLE;
    heat = 1'b0;
    duty_q = DUTY_OFF;
  endfunction

  function automatic heater_cmd_t next_heater_cmd(input logic [1:0] mode,
                                                  input logic signed [TEMP_W-1:0] temp,
                                                  input logic [TIME_W-1:0] now);
    heater_cmd_t r;
    logic [TIME_W-1:0] dur;
    r = '0;
    dur = now - phase_t0;
    case (mode)
      MODE_START: begin
        if (soak_tgt <= 0 || reflow_tgt <= 0) begin
          r.start_rejected = 1'b1;
        end else begin
          in_run = 1'b1;
          cur_phase = PH_PREHEAT;
          phase_t0 = now;
          heat = 1'b1;
          duty_q = FULL_DUTY;
        end
      end
      MODE_STOP: halt_run();
      MODE_UPDATE: begin
        if (in_run) begin
          if (temp > TRIP_TEMP) begin
            halt_run();
            r.emergency_trip = 1'b1;
          end else begin
            case (cur_phase)
              PH_PREHEAT: begin
                if (int'(temp) >= int'(soak_tgt) - int'(lag)) begin
                  cur_phase = PH_SOAK;
                  phase_t0 = now;
                end else begin
                  duty_q = FULL_DUTY;
                end
              end
              PH_SOAK: begin
                if (dur >= TIME_W'(soak_len)) begin
                  cur_phase = PH_REFLOW;
                  phase_t0 = now;
                  duty_q = FULL_DUTY;
                end else begin
                  duty_q = soak_level(soak_tgt);
                end
              end
              PH_REFLOW: begin
                if (dur < TIME_W'(reflow_len)) begin
                  // Full power only while under the reflow target less the lag offset and inside the boost window.
                  duty_q = (int'(temp) < int'(reflow_tgt) - int'(lag) &&
                            dur < TIME_W'(boost_len)) ? FULL_DUTY : DUTY_OFF;
                end else begin
                  cur_phase = PH_COOL;
                  phase_t0 = now;
                  heat = 1'b0;
                  duty_q = DUTY_OFF;
                end
              end
              PH_COOL: begin
                if (temp < COOL_DONE_TEMP) begin
                  halt_run();
                  r.run_complete = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      default: ;
    endcase
    r.phase = cur_phase;
    r.running = in_run;
    r.heater_enable = heat;
    r.duty = duty_q;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    heater_cmd_t got, want;
    if (rst) begin
      soak_tgt = SOAK_TARGET_RST;
      reflow_tgt = REFLOW_TARGET_RST;
      lag = LAG_OFFSET_RST;
      soak_len = SOAK_TIME_RST;
      reflow_len = REFLOW_TIME_RST;
      boost_len = BOOST_TIME_RST;
      in_run = 1'b0;
      cur_phase = PH_IDLE;
      phase_t0 = '0;
      duty_q = DUTY_OFF;
      heat = 1'b0;
      pending_cmds.delete();
      errors = 0;
      checked = 0;
      trips = 0;
      finishes = 0;
      refusals = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_SOAK_TARGET:   soak_tgt = pwdata[TEMP_W-1:0];
          REG_REFLOW_TARGET: reflow_tgt = pwdata[TEMP_W-1:0];
          REG_LAG_OFFSET:    lag = pwdata[LAG_W-1:0];
          REG_SOAK_TIME:     soak_len = pwdata[CFG_T_W-1:0];
          REG_REFLOW_TIME:   reflow_len = pwdata[CFG_T_W-1:0];
          REG_BOOST_TIME:    boost_len = pwdata[CFG_T_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = heater_cmd_t'(m_tdata[18:0]);
        if (pending_cmds.size() == 0) begin
          errors++;
          $display("%0t: unexpected heater command %h, nothing expected", $time, m_tdata);
        end else begin
          want = pending_cmds.pop_front();
          check_field("phase", int'(want.phase), int'(got.phase));
          check_field("running", int'(want.running), int'(got.running));
          check_field("heater_enable", int'(want.heater_enable), int'(got.heater_enable));
          check_field("duty", int'(want.duty), int'(got.duty));
          check_field("emergency_trip", int'(want.emergency_trip), int'(got.emergency_trip));
          check_field("start_rejected", int'(want.start_rejected), int'(got.start_rejected));
          check_field("run_complete", int'(want.run_complete), int'(got.run_complete));
          checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        want = next_heater_cmd(s_tuser, s_tdata[TEMP_W-1:0], s_tdata[TEMP_W+TIME_W-1:TEMP_W]);
        trips += int'(want.emergency_trip);
        finishes += int'(want.run_complete);
        refusals += int'(want.start_rejected);
        pending_cmds.push_back(want);
      end
      pending <= pending_cmds.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
// Top of the reflow profile sequencer testbench: clock, reset, stimulus and verdict.
module tb_top;
  import rps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam int PROFILES = 22;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [47:0] s_tdata;   // temperature[13:0], now_ms[45:14], zero pad
  logic [1:0]  s_tuser;   // mode[1:0]
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;   // phase[2:0], running[3], heater_enable[4], duty[15:5],
                          // emergency_trip[16], start_rejected[17], run_complete[18]

  int errors, pending, checked, trips, finishes, refusals;
  int cycles = 0;
  int items_sent = 0;
  bit gaps_on, stalls_on, broken;
  logic [31:0] clock_ms;

  // What was last written to the register bank, used to shape runs.
  int soak_t = 2400, reflow_t = 3680, lag_v = 1040;
  int unsigned soak_ms = 90000, reflow_ms = 60000;

  reflow_profile_sequencer DUT (.*);
  rps_checker checker_i (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL reflow_profile_sequencer");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stalls_on && !rst && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp_temp(input int v);
    if (v < -1024) return -1024;
    if (v > 4000) return 4000;
    return v;
  endfunction

  function automatic int unsigned pick_len();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 24'hFFFFFF;
      3: return $urandom_range(0, 24'hFFFFFF);
      default: return $urandom_range(2, 500);
    endcase
  endfunction

  task automatic send_event(input logic [1:0] mode, input int temp, input logic [31:0] t);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {2'b00, t, 14'(temp)};
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Hold off new requests until every outstanding command has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_profile(input int st, input int rt, input int lg,
                             input int unsigned sm, input int unsigned rm,
                             input int unsigned bm);
    soak_t = st;
    reflow_t = rt;
    lag_v = lg;
    soak_ms = sm;
    reflow_ms = rm;
    write_reg(REG_SOAK_TARGET, st);
    write_reg(REG_REFLOW_TARGET, rt);
    write_reg(REG_LAG_OFFSET, lg);
    write_reg(REG_SOAK_TIME, int'(sm));
    write_reg(REG_REFLOW_TIME, int'(rm));
    write_reg(REG_BOOST_TIME, int'(bm));
  endtask

  task automatic pick_profile(input int idx);
    int st, rt, lg;
    st = ($urandom_range(0, 15) == 0) ? rand_between(-1024, 0) : rand_between(1, 8191);
    rt = ($urandom_range(0, 15) == 0) ? rand_between(-1024, 0) : rand_between(1, 8191);
    case ($urandom_range(0, 4))
      0: lg = -4096;
      1: lg = 4095;
      2: lg = rand_between(-4096, 4095);
      default: lg = rand_between(0, 1500);
    endcase
    case (idx)
      0: set_profile(1, 1, -4096, 0, 0, 0);
      1: set_profile(8191, 8191, 4095, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      2: set_profile(-1024, 3680, 1040, 300, 300, 150);
      3: set_profile(2400, -1024, 1040, 300, 300, 150);
      // Soak targets on both sides of the duty clamp points.
      4: set_profile(1357, rt, 0, pick_len(), pick_len(), pick_len());
      5: set_profile(1358, rt, 0, pick_len(), pick_len(), pick_len());
      6: set_profile(5157, rt, 1000, pick_len(), pick_len(), pick_len());
      7: set_profile(5158, rt, 1000, pick_len(), pick_len(), pick_len());
      default: set_profile(st, rt, lg, pick_len(), pick_len(), pick_len());
    endcase
  endtask

  // One sample update; now and then the run is cut short by a trip, stop or restart.
  task automatic update(input int temp, input int unsigned inc);
    clock_ms += inc;
    if ($urandom_range(0, 39) == 0) begin
      broken = 1'b1;
      case ($urandom_range(0, 2))
        0: send_event(MODE_UPDATE, rand_between(4001, 8191), clock_ms);
        1: send_event(MODE_STOP, temp, clock_ms);
        default: send_event(MODE_START, temp, clock_ms);
      endcase
    end else begin
      send_event(MODE_UPDATE, temp, clock_ms);
    end
  endtask

  // Samples through a timed phase until its length has passed, ending on it exactly if slow.
  task automatic hold_phase(input int unsigned len, input int unsigned div, input int cap,
                            input int temp_lo, input int temp_hi);
    int unsigned elapsed, inc;
    int n;
    elapsed = 0;
    n = 0;
    while (!broken && (n == 0 || elapsed < len)) begin
      inc = (n == cap) ? len - elapsed : $urandom_range(0, len / div + 1);
      elapsed += inc;
      n++;
      update(rand_between(temp_lo, temp_hi), inc);
    end
  endtask

  task automatic run_once();
    int thr, rthr, n, i;
    broken = 1'b0;
    if ($urandom_range(0, 7) == 0) drain();
    if ($urandom_range(0, 3) == 0)
      send_event(2'($urandom_range(0, 3)), rand_between(-1024, 8191), $urandom);
    if ($urandom_range(0, 3) == 0) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 5000);
    send_event(MODE_START, rand_between(-1024, 8191), clock_ms);
    thr = soak_t - lag_v;
    n = $urandom_range(0, 3);
    for (i = 0; i < n && thr > -1024 && !broken; i++)
      update(rand_between(-1024, clamp_temp(thr - 1)), $urandom_range(0, 50));
    if (!broken) update(clamp_temp(thr + rand_between(0, 40)), $urandom_range(0, 50));
    hold_phase(soak_ms, 3, 7, -1024, 4000);
    rthr = reflow_t - lag_v;
    hold_phase(reflow_ms, 4, 9, clamp_temp(rthr - 300), clamp_temp(rthr + 300));
    n = $urandom_range(0, 2);
    for (i = 0; i < n && !broken; i++)
      update(rand_between(1600, 4000), $urandom_range(0, 1000));
    if (!broken) update(rand_between(-1024, 1599), $urandom_range(0, 1000));
  endtask

  initial begin
    logic [31:0] t, r;
    int budget;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= MODE_UPDATE;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    clock_ms = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed walk through a full run on the reset profile, timed across the wrap of now_ms.
    t = 32'hFFFF_FF00;
    r = t + 32'd90003;
    send_event(MODE_UPDATE, 8191, 0);
    send_event(MODE_STOP, 0, 0);
    send_event(MODE_RSVD, 100, 5);
    send_event(MODE_START, -1024, t);
    send_event(MODE_UPDATE, -1024, t + 1);
    send_event(MODE_UPDATE, 1359, t + 2);
    send_event(MODE_UPDATE, 1360, t + 3);
    send_event(MODE_UPDATE, 2000, t + 3 + 89999);
    send_event(MODE_UPDATE, 2000, r);
    send_event(MODE_UPDATE, 2639, r);
    send_event(MODE_UPDATE, 2640, r + 1);
    send_event(MODE_UPDATE, 100, r + 29999);
    send_event(MODE_UPDATE, 100, r + 30000);
    send_event(MODE_UPDATE, 3000, r + 60000);
    send_event(MODE_UPDATE, 1600, r + 60001);
    send_event(MODE_UPDATE, 1599, r + 60002);
    send_event(MODE_START, 0, 10);
    send_event(MODE_UPDATE, 4000, 11);
    send_event(MODE_UPDATE, 4001, 12);
    send_event(MODE_START, 0, 20);
    send_event(MODE_START, 0, 30);
    send_event(MODE_STOP, 0, 31);
    drain();
    write_reg(REG_SOAK_TARGET, 0);
    send_event(MODE_START, 0, 40);
    drain();
    write_reg(REG_SOAK_TARGET, 2400);
    write_reg(REG_REFLOW_TARGET, -1);
    send_event(MODE_START, 0, 50);
    drain();

    for (int p = 0; p < PROFILES; p++) begin
      // The last few profiles run without idling on either side.
      gaps_on = (p < PROFILES - 3) && $urandom_range(0, 3) != 0;
      stalls_on = (p < PROFILES - 3) && $urandom_range(0, 3) != 0;
      pick_profile(p);
      budget = items_sent + 24;
      while (items_sent < budget) run_once();
      drain();
    end

    stalls_on = 1'b0;
    repeat (8) @(posedge clk);
    $display("Ran %0d events over %0d register profiles with idling on both sides.",
             items_sent, PROFILES + 3);
    $display("Checked %0d commands: %0d over-temperature trips, %0d finished runs, %0d refused starts.",
             checked, trips, finishes, refusals);
    if (errors == 0) begin
      $display("PASS reflow_profile_sequencer");
    end else begin
      $display("FAIL reflow_profile_sequencer");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/rps_pkg.sv
hdl/rps_cfg_regs.sv
hdl/rps_soak_duty.sv
hdl/rps_core.sv
hdl/reflow_profile_sequencer.sv
tb/rps_checker.sv
tb/tb_top.sv
